>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the interval overlap tracker.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KIOT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KIOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/kiot_pkg.sv
// Package for the interval overlap tracker: sizes, field widths and state codes.
// Has no dependencies; used by k_interval_overlap_tracker.
`default_nettype none

package kiot_pkg;

    localparam int MAX_GROUP = 256;
    localparam int HEAP_AW   = $clog2(MAX_GROUP);
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);

    localparam int COORD_W   = 32;
    localparam int LEN_W     = COORD_W + 1;
    localparam int GROUP_W   = 9;

    localparam int IN_W      = 2 * COORD_W;
    localparam int OUT_W     = LEN_W + 2 * COORD_W;
    localparam int OUT_BUS_W = ((OUT_W + 7) / 8) * 8;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [HEAP_AW-1:0]        heap_addr_t;
    typedef logic [CNT_W-1:0]          heap_cnt_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_POP_CHK,
        ST_POP_LD,
        ST_CHECK,
        ST_OUT
    } kiot_state_t;

endpackage

`default_nettype wire

>>> rtl/k_interval_overlap_tracker.sv
// Best common overlap of a group of intervals, kept with a min-heap of right ends.
// Depends on kiot_pkg and assert_macros.svh; the heap lives in an internal memory.
// In a transaction each heap level of a sift takes a memory read state and a compare-write
// state (ST_INS_RD/ST_INS_CMP, ST_DN_RD/ST_DN_CMP); the result is offered after ST_CHECK.
// The input is not ready until the result is loaded: one item is taken at a time.
// Reset (rst_n, asynchronous, active low) empties the heap, clears the best, sets size 1.
`default_nettype none
`include "assert_macros.svh"

module k_interval_overlap_tracker
    import kiot_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [GROUP_W-1:0]   cfg_data,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,   // item_left, item_right
    input  wire logic [0:0]           s_tuser,   // first_item

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_BUS_W-1:0]      m_tdata    // best_length, best_left, best_right, zero pad
);

    coord_t      heap_mem [MAX_GROUP];

    kiot_state_t state_reg, state_next;
    heap_cnt_t   cnt_reg, cnt_next;
    logic        popping_reg, popping_next;
    logic [LEN_W-1:0] best_len_reg, best_len_next;
    coord_t      best_lo_reg, best_lo_next;
    coord_t      best_hi_reg, best_hi_next;
    logic [GROUP_W-1:0] gs_reg;
    logic        out_valid_reg, out_valid_next;

    coord_t      val_reg, val_next;
    coord_t      left_reg, left_next;
    heap_addr_t  pos_reg, pos_next;
    logic [LEN_W-1:0] out_len_reg;
    coord_t      out_lo_reg, out_hi_reg;
    logic        out_load;

    coord_t      rd0_reg, rd1_reg, top_reg;
    heap_addr_t  rd_addr0, rd_addr1, wr_addr;
    coord_t      wr_data;
    logic        wr_en;

    heap_cnt_t   k_eff, in_cnt, cnt_dec, l_idx, r_idx;
    heap_addr_t  parent_idx;
    logic        l_ok, r_ok, take_l, take_r;
    coord_t      min_l, in_right;
    logic signed [COORD_W+1:0] ovl;
    logic        ovl_pos;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_BUS_W - OUT_W){1'b0}}, out_hi_reg, out_lo_reg, out_len_reg};

    assign in_right  = s_tdata[IN_W-1:COORD_W];
    assign in_cnt    = s_tuser[0] ? '0 : cnt_reg;
    assign cnt_dec   = cnt_reg - 1'b1;
    assign parent_idx = (pos_reg - 1'b1) >> 1;
    assign l_idx     = {pos_reg, 1'b1};
    assign r_idx     = l_idx + 1'b1;
    assign l_ok      = (l_idx < cnt_reg);
    assign r_ok      = (r_idx < cnt_reg);
    assign take_l    = (rd0_reg < val_reg);
    assign min_l     = take_l ? rd0_reg : val_reg;
    assign take_r    = r_ok && (rd1_reg < min_l);

    assign ovl     = {{2{top_reg[COORD_W-1]}}, top_reg} - {{2{left_reg[COORD_W-1]}}, left_reg}
                     + (COORD_W+2)'(1);
    assign ovl_pos = !ovl[COORD_W+1] && (ovl != '0);

    always_comb
    begin
        if (gs_reg == '0)
            k_eff = CNT_W'(1);
        else if ((GROUP_W+1)'(gs_reg) > (GROUP_W+1)'(MAX_GROUP))
            k_eff = CNT_W'(MAX_GROUP);
        else
            k_eff = CNT_W'(gs_reg);
    end

    always_comb
    begin
        unique case (state_reg)
            ST_INS_RD:  rd_addr0 = parent_idx;
            ST_DN_RD:   rd_addr0 = l_idx[HEAP_AW-1:0];
            ST_POP_CHK: rd_addr0 = cnt_dec[HEAP_AW-1:0];
            default:    rd_addr0 = '0;
        endcase
        rd_addr1 = r_idx[HEAP_AW-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        popping_next   = popping_reg;
        best_len_next  = best_len_reg;
        best_lo_next   = best_lo_reg;
        best_hi_next   = best_hi_reg;
        out_valid_next = out_valid_reg && !m_tready;
        val_next       = val_reg;
        left_next      = left_reg;
        pos_next       = pos_reg;
        out_load       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = val_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    left_next    = s_tdata[COORD_W-1:0];
                    val_next     = in_right;
                    popping_next = 1'b0;
                    if (s_tuser[0])
                    begin
                        best_len_next = '0;
                        best_lo_next  = '0;
                        best_hi_next  = '0;
                    end
                    cnt_next = in_cnt;
                    if (in_cnt < CNT_W'(MAX_GROUP))
                    begin
                        pos_next   = in_cnt[HEAP_AW-1:0];
                        cnt_next   = in_cnt + 1'b1;
                        state_next = ST_INS_RD;
                    end
                    else if (in_right > top_reg)
                    begin
                        pos_next   = '0;
                        state_next = ST_DN_RD;
                    end
                    else
                    begin
                        state_next = ST_POP_CHK;
                    end
                end
            end

            ST_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_POP_CHK;
                end
                else
                begin
                    state_next = ST_INS_CMP;
                end
            end

            ST_INS_CMP:
            begin
                wr_en = 1'b1;
                if (rd0_reg > val_reg)
                begin
                    wr_data    = rd0_reg;
                    pos_next   = parent_idx;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    state_next = ST_POP_CHK;
                end
            end

            ST_DN_RD:
            begin
                if (!l_ok)
                begin
                    wr_en      = 1'b1;
                    state_next = popping_reg ? ST_CHECK : ST_POP_CHK;
                end
                else
                begin
                    state_next = ST_DN_CMP;
                end
            end

            ST_DN_CMP:
            begin
                wr_en = 1'b1;
                if (take_r)
                begin
                    wr_data    = rd1_reg;
                    pos_next   = r_idx[HEAP_AW-1:0];
                    state_next = ST_DN_RD;
                end
                else if (take_l)
                begin
                    wr_data    = rd0_reg;
                    pos_next   = l_idx[HEAP_AW-1:0];
                    state_next = ST_DN_RD;
                end
                else
                begin
                    state_next = popping_reg ? ST_CHECK : ST_POP_CHK;
                end
            end

            ST_POP_CHK:
            begin
                if (cnt_reg > k_eff)
                begin
                    cnt_next     = cnt_dec;
                    popping_next = 1'b1;
                    state_next   = ST_POP_LD;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_POP_LD:
            begin
                val_next   = rd0_reg;
                pos_next   = '0;
                state_next = ST_DN_RD;
            end

            ST_CHECK:
            begin
                if (cnt_reg >= k_eff && cnt_reg != '0 && ovl_pos
                    && ovl[LEN_W-1:0] > best_len_reg)
                begin
                    best_len_next = ovl[LEN_W-1:0];
                    best_lo_next  = left_reg;
                    best_hi_next  = top_reg;
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            popping_reg   <= 1'b0;
            best_len_reg  <= '0;
            best_lo_reg   <= '0;
            best_hi_reg   <= '0;
            gs_reg        <= GROUP_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            popping_reg   <= popping_next;
            best_len_reg  <= best_len_next;
            best_lo_reg   <= best_lo_next;
            best_hi_reg   <= best_hi_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                gs_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        left_reg <= left_next;
        pos_reg  <= pos_next;
        if (out_load)
        begin
            out_len_reg <= best_len_reg;
            out_lo_reg  <= best_lo_reg;
            out_hi_reg  <= best_hi_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            heap_mem[wr_addr] <= wr_data;
        rd0_reg <= heap_mem[rd_addr0];
        rd1_reg <= heap_mem[rd_addr1];
    end

    // The root of the heap is mirrored so the overlap check needs no memory read.
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_addr == '0)
            top_reg <= wr_data;
    end

    `KIOT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(MAX_GROUP), "heap count overflow")
    `KIOT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `KIOT_ASSERT_NOW(a_pos_valid, state_reg == ST_DN_RD || state_reg == ST_INS_RD,
        CNT_W'(pos_reg) < cnt_reg, "sift position outside heap")
    `KIOT_ASSERT_NEXT(a_best_mono, state_reg != ST_IDLE,
        best_len_reg >= $past(best_len_reg), "best overlap shrank")

endmodule

`default_nettype wire

>>> dv/k_interval_overlap_tracker_tb.sv
// Testbench for k_interval_overlap_tracker: drives interval runs through the stream ports
// and checks every result against its own tracker of the best group overlap.
// Depends on kiot_pkg and the k_interval_overlap_tracker RTL only.
`timescale 1ns / 100ps

module k_interval_overlap_tracker_tb;
    import kiot_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned SETTLE_WAIT  = 50;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 40;
    localparam longint      COORD_MAX    = 64'sh7fff_ffff;
    localparam longint      COORD_MIN    = -64'sh8000_0000;
    localparam coord_t      LOWEST       = 32'sh8000_0000;
    localparam coord_t      HIGHEST      = 32'sh7fff_ffff;

    typedef enum {RUN_NARROW, RUN_WIDE, RUN_EDGE} run_shape_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        coord_t           left;
        coord_t           right;
    } overlap_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [GROUP_W-1:0]   cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;   // item_left, item_right
    logic [0:0]           s_tuser = '0;   // first_item
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_BUS_W-1:0] m_tdata;        // best_length, best_left, best_right, zero pad

    coord_t               kept_rights[$];
    logic [LEN_W-1:0]     best_len = '0;
    coord_t               best_lo = '0;
    coord_t               best_hi = '0;
    logic [GROUP_W-1:0]   group_reg = 9'd1;
    overlap_t             pending_overlaps[$];

    int unsigned          mismatch_count = 0;
    int unsigned          cycle_count = 0;
    logic                 no_idle = 1'b0;
    int unsigned          hold_req = 0;
    int unsigned          hold_ack = 0;
    int unsigned          hold_left = 0;

    k_interval_overlap_tracker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= no_idle || ($urandom_range(99) >= 26);
        end
    end

    always @(posedge clk)
    begin : check_results
        overlap_t want;
        overlap_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.length = m_tdata[LEN_W-1:0];
            got.left   = m_tdata[LEN_W +: COORD_W];
            got.right  = m_tdata[LEN_W + COORD_W +: COORD_W];
            if (pending_overlaps.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                want = pending_overlaps.pop_front();
                if (got.length !== want.length)
                begin
                    $error("best_length: expected %0d, got %0d", want.length, got.length);
                    mismatch_count = mismatch_count + 1;
                end
                if (got.left !== want.left)
                begin
                    $error("best_left: expected %0d, got %0d", want.left, got.left);
                    mismatch_count = mismatch_count + 1;
                end
                if (got.right !== want.right)
                begin
                    $error("best_right: expected %0d, got %0d", want.right, got.right);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // The kept right ends are held sorted, so the smallest one is always at the front.
    function automatic overlap_t track_interval(logic first, coord_t left, coord_t right);
        int unsigned k;
        int unsigned pos;
        longint      span;
        k = 32'(group_reg);
        if (k == 0)
            k = 1;
        if (k > MAX_GROUP)
            k = MAX_GROUP;
        if (first)
        begin
            kept_rights.delete();
            best_len = '0;
            best_lo  = '0;
            best_hi  = '0;
        end
        if (kept_rights.size() < MAX_GROUP || right > kept_rights[0])
        begin
            pos = 0;
            while (pos < kept_rights.size() && kept_rights[pos] <= right)
                pos++;
            kept_rights.insert(pos, right);
            if (kept_rights.size() > MAX_GROUP)
                void'(kept_rights.pop_front());
        end
        if (kept_rights.size() > k)
            void'(kept_rights.pop_front());
        if (kept_rights.size() >= k)
        begin
            span = longint'(kept_rights[0]) - longint'(left) + 1;
            if (span > 0 && span > longint'(best_len))
            begin
                best_len = span[LEN_W-1:0];
                best_lo  = left;
                best_hi  = kept_rights[0];
            end
        end
        return {best_len, best_lo, best_hi};
    endfunction

    function automatic coord_t clamp_coord(longint v);
        if (v > COORD_MAX)
            return HIGHEST;
        if (v < COORD_MIN)
            return LOWEST;
        return coord_t'(v[COORD_W-1:0]);
    endfunction

    task automatic send_interval(input logic first, input coord_t left, input coord_t right);
        if (!no_idle && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        pending_overlaps.push_back(track_interval(first, left, right));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_overlaps.size() != 0);
    endtask

    task automatic write_group_size(input logic [GROUP_W-1:0] value);
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        group_reg = value;
    endtask

    task automatic send_sorted_run(input int unsigned count, input run_shape_t shape,
                                   input logic fresh);
        longint origin;
        longint step;
        longint reach;
        coord_t left;
        coord_t right;
        coord_t prev_left;
        coord_t prev_right;
        prev_left  = '0;
        prev_right = '0;
        for (int unsigned n = 0; n < count; n++)
        begin
            case (shape)
                RUN_NARROW:
                begin
                    origin = longint'($urandom_range(200)) - 100;
                    step   = $urandom_range(20);
                    reach  = longint'($urandom_range(60)) - 5;
                end
                RUN_WIDE:
                begin
                    origin = longint'($signed($urandom));
                    step   = $urandom_range(1 << 28);
                    reach  = longint'($urandom_range(1 << 30)) - (1 << 26);
                end
                default:
                begin
                    origin = $urandom_range(1) ? COORD_MIN + $urandom_range(50)
                                               : COORD_MAX - $urandom_range(5000);
                    step   = $urandom_range(200);
                    reach  = ($urandom_range(3) == 0) ? longint'($urandom)
                                                      : longint'($urandom_range(1000)) - 10;
                end
            endcase
            if ($urandom_range(3) == 0)
                step = 0;
            left  = clamp_coord((n == 0) ? origin : longint'(prev_left) + step);
            right = clamp_coord(longint'(left) + reach);
            if (n != 0 && left == prev_left && right < prev_right)
                right = prev_right;
            send_interval(fresh && n == 0, left, right);
            prev_left  = left;
            prev_right = right;
        end
    endtask

    task automatic test_extremes();
        send_interval(1'b1, LOWEST, HIGHEST);
        send_interval(1'b0, HIGHEST, HIGHEST);
        send_interval(1'b0, HIGHEST, LOWEST);
        send_interval(1'b1, 32'sd0, -32'sd1);
        send_interval(1'b0, 32'sd5, LOWEST);
        send_interval(1'b1, LOWEST, LOWEST);
        send_interval(1'b0, -32'sd10, 32'sd10);
        send_interval(1'b1, HIGHEST, HIGHEST);
    endtask

    task automatic test_group_sizes();
        write_group_size('0);
        send_interval(1'b1, -32'sd3, 32'sd4);
        send_interval(1'b0, 32'sd1, 32'sd2);
        write_group_size(9'd3);
        send_interval(1'b1, 32'sd0, 32'sd10);
        send_interval(1'b0, 32'sd2, 32'sd6);
        send_interval(1'b0, 32'sd2, 32'sd9);
        send_interval(1'b0, 32'sd4, 32'sd20);
        send_interval(1'b0, 32'sd4, 32'sd20);
        send_interval(1'b0, 32'sd8, 32'sd30);
        write_group_size(9'd511);
        send_interval(1'b1, 32'sd0, 32'sd100);
        send_interval(1'b0, 32'sd1, 32'sd100);
        write_group_size(9'd1);
    endtask

    task automatic test_lowered_group();
        write_group_size(9'd5);
        send_sorted_run(8, RUN_NARROW, 1'b1);
        write_group_size(9'd2);
        send_sorted_run(4, RUN_NARROW, 1'b0);
    endtask

    task automatic test_full_heap();
        write_group_size(9'd300);
        send_sorted_run(300, RUN_NARROW, 1'b1);
        write_group_size(9'd256);
        send_sorted_run(3, RUN_NARROW, 1'b0);
        write_group_size(9'd3);
        send_sorted_run(4, RUN_NARROW, 1'b0);
    endtask

    task automatic test_backpressure();
        write_group_size(9'd2);
        hold_req <= hold_req + 1;
        no_idle  <= 1'b1;
        send_sorted_run(12, RUN_NARROW, 1'b1);
        wait_drained();
        send_sorted_run(6, RUN_WIDE, 1'b1);
        no_idle <= 1'b0;
    endtask

    task automatic test_random();
        int unsigned sent;
        int unsigned runs;
        int unsigned count;
        int unsigned pick;
        sent = 0;
        runs = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (runs % 6 == 0)
            begin
                pick = $urandom_range(9);
                if (pick == 0)
                    write_group_size('0);
                else if (pick == 1)
                    write_group_size(GROUP_W'(MAX_GROUP));
                else if (pick == 2)
                    write_group_size(GROUP_W'($urandom_range(511)));
                else
                    write_group_size(GROUP_W'($urandom_range(1, 6)));
            end
            no_idle <= (runs >= 1 && runs < 4);
            count = $urandom_range(1, 16);
            pick  = $urandom_range(99);
            if (pick < 80)
                send_sorted_run(count, run_shape_t'($urandom_range(2)), 1'b1);
            else if (pick < 90)
                send_sorted_run(count, run_shape_t'($urandom_range(2)), 1'b0);
            else
                repeat (count) send_interval(1'($urandom_range(1)), coord_t'($urandom),
                                             coord_t'($urandom));
            sent = sent + count;
            runs = runs + 1;
        end
        no_idle <= 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_group_sizes();
        test_lowered_group();
        test_full_heap();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
